@@ src/pgr_pkg.sv @@
// shared types and constants for the polyline grid rasterizer
package pgr_pkg;

    localparam int FIELD_W = 6;
    localparam int DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    // one queued line segment, coordinates already masked to the grid
    typedef struct packed {
        logic [FIELD_W-1:0] x0;
        logic [FIELD_W-1:0] y0;
        logic [FIELD_W-1:0] x1;
        logic [FIELD_W-1:0] y1;
        logic               skip_first;
    } seg_cmd_t;

endpackage

@@ src/polyline_grid_rasterizer.sv @@
// polyline rasterizer top level: waypoint intake, segment queue and line walker
// the segment queue lets waypoints arrive while the walker is still busy with an earlier segment
// a segment is loaded from the queue before the walker steps along it; start waypoints queue nothing
// the walker emits one cell per cycle through the output register while the output is not stalled
// reset: rst_n clears the stored waypoint, the queue and the output valid at once
module polyline_grid_rasterizer #(
    parameter int COORD_BITS = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [pgr_pkg::DATA_W-1:0] s_tdata,  // point_x, point_y, zero fill
    input  logic                       s_tuser,  // new_polyline
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pgr_pkg::DATA_W-1:0] m_tdata,  // cell_x, cell_y, zero fill
    output logic                       m_tlast   // segment_end
);

    pgr_pkg::seg_cmd_t q_cmd;
    logic              q_valid;
    logic              q_pop;

    pgr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    pgr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

@@ src/pgr_front.sv @@
// waypoint intake: keeps the previous point and queues line segments
module pgr_front #(
    parameter int COORD_BITS = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [pgr_pkg::DATA_W-1:0] s_tdata,  // point_x, point_y, zero fill
    input  logic                     s_tuser,    // new_polyline
    output pgr_pkg::seg_cmd_t        q_cmd,
    output logic                     q_valid,
    input  logic                     q_pop
);

    localparam int FW = pgr_pkg::FIELD_W;
    localparam logic [FW-1:0] COORD_MASK = FW'((1 << COORD_BITS) - 1);

    pgr_pkg::seg_cmd_t fifo_reg [pgr_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    logic [FW-1:0] prev_x_reg;
    logic [FW-1:0] prev_y_reg;
    logic          have_prev_reg;
    logic          past_first_reg;

    logic [FW-1:0]     px;
    logic [FW-1:0]     py;
    logic              accept;
    logic              is_start;
    logic              push;
    logic              full;
    pgr_pkg::seg_cmd_t new_cmd;

    assign px       = s_tdata[FW-1:0] & COORD_MASK;
    assign py       = s_tdata[2*FW-1:FW] & COORD_MASK;
    assign full     = (count_reg == 2'(pgr_pkg::QUEUE_DEPTH));
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;
    // a waypoint with nothing stored before it opens a polyline too
    assign is_start = s_tuser || !have_prev_reg;
    assign push     = accept && !is_start;

    assign new_cmd.x0         = prev_x_reg;
    assign new_cmd.y0         = prev_y_reg;
    assign new_cmd.x1         = px;
    assign new_cmd.y1         = py;
    assign new_cmd.skip_first = past_first_reg;

    assign q_cmd   = fifo_reg[rd_ptr_reg];
    assign q_valid = (count_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= 2'd0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            have_prev_reg  <= 1'b0;
            past_first_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_x_reg     <= px;
                prev_y_reg     <= py;
                have_prev_reg  <= 1'b1;
                past_first_reg <= !is_start;
            end
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop && q_valid)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, q_pop && q_valid})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= new_cmd;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(pgr_pkg::QUEUE_DEPTH))
        else $error("segment queue overfilled");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("segment pushed into full queue");

    a_start_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_start) |=> (count_reg <= $past(count_reg)))
        else $error("start waypoint queued a segment");

endmodule

@@ src/pgr_back.sv @@
// bresenham walker: steps one cell per cycle into a registered output, unless the output stalls
module pgr_back #(
    parameter int COORD_BITS = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pgr_pkg::seg_cmd_t          q_cmd,
    input  logic                       q_valid,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pgr_pkg::DATA_W-1:0] m_tdata,  // cell_x, cell_y, zero fill
    output logic                       m_tlast   // segment_end
);

    localparam int CB = COORD_BITS;
    localparam int FW = pgr_pkg::FIELD_W;
    localparam int EW = COORD_BITS + 2;

    logic                 busy_reg;
    logic                 skip_reg;
    logic [CB-1:0]        cur_x_reg;
    logic [CB-1:0]        cur_y_reg;
    logic [CB-1:0]        end_x_reg;
    logic [CB-1:0]        end_y_reg;
    logic [CB-1:0]        dx_reg;
    logic [CB-1:0]        dy_reg;
    logic                 sx_reg;
    logic                 sy_reg;
    logic signed [EW-1:0] err_reg;

    logic          m_valid_reg;
    logic [FW-1:0] cell_x_reg;
    logic [FW-1:0] cell_y_reg;
    logic          last_reg;

    logic [CB-1:0]        ld_x0;
    logic [CB-1:0]        ld_y0;
    logic [CB-1:0]        ld_x1;
    logic [CB-1:0]        ld_y1;
    logic [CB-1:0]        ld_dx;
    logic [CB-1:0]        ld_dy;
    logic                 can_emit;
    logic                 advance;
    logic                 emit;
    logic                 at_end;
    logic signed [EW:0]   e2;
    logic signed [EW:0]   dx_w;
    logic signed [EW:0]   dy_w;
    logic                 step_x;
    logic                 step_y;
    logic signed [EW-1:0] err_next;

    assign ld_x0 = q_cmd.x0[CB-1:0];
    assign ld_y0 = q_cmd.y0[CB-1:0];
    assign ld_x1 = q_cmd.x1[CB-1:0];
    assign ld_y1 = q_cmd.y1[CB-1:0];
    assign ld_dx = (ld_x1 > ld_x0) ? (ld_x1 - ld_x0) : (ld_x0 - ld_x1);
    assign ld_dy = (ld_y1 > ld_y0) ? (ld_y1 - ld_y0) : (ld_y0 - ld_y1);

    assign q_pop    = !busy_reg && q_valid;
    assign can_emit = !m_valid_reg || m_tready;
    // a skipped start cell needs no output slot
    assign advance  = busy_reg && (skip_reg || can_emit);
    assign emit     = advance && !skip_reg;
    assign at_end   = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);

    // doubled error tests
    assign e2     = {err_reg, 1'b0};
    assign dx_w   = $signed({{(EW + 1 - CB){1'b0}}, dx_reg});
    assign dy_w   = $signed({{(EW + 1 - CB){1'b0}}, dy_reg});
    assign step_x = (e2 > -dy_w);
    assign step_y = (e2 < dx_w);

    always_comb
    begin
        err_next = err_reg;
        if (step_x)
            err_next = err_next - EW'(dy_w);
        if (step_y)
            err_next = err_next + EW'(dx_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                busy_reg <= 1'b1;
            else if (advance && at_end)
                busy_reg <= 1'b0;

            if (emit)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_x_reg <= ld_x0;
            cur_y_reg <= ld_y0;
            end_x_reg <= ld_x1;
            end_y_reg <= ld_y1;
            dx_reg    <= ld_dx;
            dy_reg    <= ld_dy;
            sx_reg    <= (ld_x0 < ld_x1);
            sy_reg    <= (ld_y0 < ld_y1);
            err_reg   <= EW'($signed({2'b00, ld_dx})) - EW'($signed({2'b00, ld_dy}));
            skip_reg  <= q_cmd.skip_first;
        end
        else if (advance)
        begin
            skip_reg <= 1'b0;
            err_reg  <= err_next;
            if (step_x)
                cur_x_reg <= sx_reg ? (cur_x_reg + CB'(1)) : (cur_x_reg - CB'(1));
            if (step_y)
                cur_y_reg <= sy_reg ? (cur_y_reg + CB'(1)) : (cur_y_reg - CB'(1));
        end

        if (emit)
        begin
            cell_x_reg <= FW'(cur_x_reg);
            cell_y_reg <= FW'(cur_y_reg);
            last_reg   <= at_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(pgr_pkg::DATA_W - 2 * FW){1'b0}}, cell_y_reg, cell_x_reg};
    assign m_tlast  = last_reg;

    a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && at_end) |=> !busy_reg)
        else $error("walker still busy after final cell");

    a_last_is_endpoint: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && at_end) |=> (m_tlast && cell_x_reg == FW'($past(end_x_reg))
                              && cell_y_reg == FW'($past(end_y_reg))))
        else $error("segment end cell differs from waypoint");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !q_pop)
        else $error("segment loaded while walker busy");

endmodule
